@@ hw/rtl/spkl_pkg.sv @@
// Package for the sorted page key lookup: sizes, codes, item and control types.
`timescale 1ns / 1ps
package spkl_pkg;

  localparam int ENTRY_SLOTS = 256;
  localparam int IDX_W       = $clog2(ENTRY_SLOTS);
  localparam int CNT_W       = $clog2(ENTRY_SLOTS + 1);
  localparam int KEY_W       = 64;
  localparam int REC_W       = 64;
  localparam int LINK_W      = 64;
  localparam int ENT_W       = KEY_W + REC_W;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_LINK   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [REC_W-1:0]  record_id;
    logic [LINK_W-1:0] link_addr;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [REC_W-1:0]  found_record;
    logic [8:0]        count_now;
    logic              full_flag;
    logic              link_present;
    logic [LINK_W-1:0] link_value;
    logic              status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic set_link;
    logic reject;
    logic srch_issue;
    logic srch_step;
    logic probe_issue;
    logic probe_check;
    logic shift_issue;
    logic shift_write;
    logic put;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic srch_done;
    logic probe_ok;
    logic shift_done;
  } dp_status_t;

endpackage

@@ hw/rtl/spkl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spkl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/spkl_ctrl.sv @@
// Controller state machine sequencing decode, search, probe, shift, put and response steps.
`timescale 1ns / 1ps
module spkl_ctrl import spkl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t st,
  output dp_cmd_t    dc,
  output logic       busy,
  output logic       done
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (st.cmd)
          CMD_CLEAR:  state_next = S_RESP;
          CMD_LINK:   state_next = S_RESP;
          CMD_INSERT: state_next = st.full ? S_RESP : S_SRCH_RD;
          CMD_LOOKUP: state_next = S_SRCH_RD;
        endcase
      end
      S_SRCH_RD: begin
        if (!st.srch_done) begin
          state_next = S_SRCH_CMP;
        end else if (st.cmd == CMD_INSERT) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_PROBE_RD;
        end
      end
      S_SRCH_CMP:  state_next = S_SRCH_RD;
      S_PROBE_RD:  state_next = st.probe_ok ? S_PROBE_CMP : S_RESP;
      S_PROBE_CMP: state_next = S_RESP;
      S_SHIFT_RD:  state_next = st.shift_done ? S_PUT : S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_PUT:       state_next = S_RESP;
      S_RESP:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    dc             = '0;
    dc.load        = (state == S_IDLE) && start;
    dc.clear       = (state == S_DECODE) && (st.cmd == CMD_CLEAR);
    dc.set_link    = (state == S_DECODE) && (st.cmd == CMD_LINK);
    dc.reject      = (state == S_DECODE) && (st.cmd == CMD_INSERT) && st.full;
    dc.srch_issue  = (state == S_SRCH_RD) && !st.srch_done;
    dc.srch_step   = (state == S_SRCH_CMP);
    dc.probe_issue = (state == S_PROBE_RD) && st.probe_ok;
    dc.probe_check = (state == S_PROBE_CMP);
    dc.shift_issue = (state == S_SHIFT_RD) && !st.shift_done;
    dc.shift_write = (state == S_SHIFT_WR);
    dc.put         = (state == S_PUT);
    busy           = (state != S_IDLE);
    done           = (state == S_RESP);
  end

endmodule

@@ hw/rtl/spkl_dp.sv @@
// Datapath: item register, search bounds, shift index, page state and entry RAM.
`timescale 1ns / 1ps
module spkl_dp import spkl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  dp_cmd_t    dc,
  output dp_status_t st,
  output result_t    result
);

  item_t             cur;
  logic [CNT_W-1:0]  lo, hi, shift_idx, count;
  logic [LINK_W-1:0] link;
  logic              found, status;
  logic [REC_W-1:0]  found_record;

  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  shift_src;
  logic [ENT_W-1:0]  rdata, wdata;
  logic [KEY_W-1:0]  rkey;
  logic [IDX_W-1:0]  raddr, waddr;
  logic              re, we, go_right;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CNT_W:1];
  assign shift_src = shift_idx - CNT_W'(1);
  assign rkey      = rdata[ENT_W-1:REC_W];

  // insert searches past equal keys so a new pair lands after them
  assign go_right = (cur.cmd == CMD_INSERT) ? (rkey <= cur.key) : (rkey < cur.key);

  always_comb begin
    re = dc.srch_issue || dc.probe_issue || dc.shift_issue;
    priority if (dc.srch_issue) begin
      raddr = mid[IDX_W-1:0];
    end else if (dc.probe_issue) begin
      raddr = lo[IDX_W-1:0];
    end else begin
      raddr = shift_src[IDX_W-1:0];
    end
    we = dc.shift_write || dc.put;
    if (dc.put) begin
      waddr = lo[IDX_W-1:0];
      wdata = {cur.key, cur.record_id};
    end else begin
      waddr = shift_idx[IDX_W-1:0];
      wdata = rdata;
    end
  end

  spkl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRY_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // page state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      link  <= '0;
    end else begin
      if (dc.clear) begin
        count <= '0;
        link  <= '0;
      end
      if (dc.set_link) link <= cur.link_addr;
      if (dc.put) count <= count + CNT_W'(1);
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (dc.load) begin
      cur          <= item;
      lo           <= '0;
      hi           <= count;
      shift_idx    <= count;
      found        <= 1'b0;
      found_record <= '0;
      status       <= 1'b0;
    end
    if (dc.reject) status <= 1'b1;
    if (dc.srch_step) begin
      if (go_right) lo <= mid + CNT_W'(1);
      else          hi <= mid;
    end
    if (dc.probe_check && (rkey == cur.key)) begin
      found        <= 1'b1;
      found_record <= rdata[REC_W-1:0];
    end
    if (dc.shift_write) shift_idx <= shift_src;
  end

  always_comb begin
    st.cmd        = cur.cmd;
    st.full       = (count >= CNT_W'(ENTRY_SLOTS));
    st.srch_done  = (lo >= hi);
    st.probe_ok   = (lo < count);
    st.shift_done = (shift_idx == lo);

    result.found        = found;
    result.found_record = found_record;
    result.count_now    = 9'(count);
    result.full_flag    = (count == CNT_W'(ENTRY_SLOTS));
    result.link_present = (link != '0);
    result.link_value   = link;
    result.status       = status;
  end

endmodule

@@ hw/rtl/sorted_page_key_lookup_top.sv @@
// Sorted index page: clear, set link and a rejected insert go from decode straight to the response.
// Lookup: a binary search, then a probe of the found slot; each search step is a RAM read.
// Insert: binary search, one shift read and write per entry moved, then the put; one RAM port pair.
// One item at a time; the next is taken the cycle after done. Receiver cannot stall.
// Reset clears the pair count and overflow link; entry RAM contents are not cleared.
`timescale 1ns / 1ps
module sorted_page_key_lookup_top import spkl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  dp_cmd_t    dc;
  dp_status_t st;

  spkl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .dc   (dc),
    .busy (busy),
    .done (done)
  );

  spkl_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .dc    (dc),
    .st    (st),
    .result(result)
  );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the sorted page key lookup: directed and random command items against a page predictor.
`timescale 1ns / 1ps
module tb_top;
  import spkl_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // above the longest insert plus gaps
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_TARGET = 620;

  typedef struct {
    item_t       it;
    bit          drain;  // hold this item back until every result is in
    int unsigned gap;    // idle cycles after this item is taken
  } send_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   cmd_item = '0;
  logic    busy;
  logic    done;
  result_t result_out;

  sorted_page_key_lookup_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (cmd_item),
    .busy   (busy),
    .done   (done),
    .result (result_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // page predictor state
  logic [KEY_W-1:0] page_keys [ENTRY_SLOTS];
  logic [REC_W-1:0] page_recs [ENTRY_SLOTS];
  int               page_count = 0;
  logic [LINK_W-1:0] page_link = '0;

  send_t   items_to_send[$];
  result_t results_due[$];
  int      items_total = 0;
  int      items_accepted = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int unsigned gap_left = 0;
  logic    item_taken = 1'b0;
  bit      timed_out = 0;

  // generator-side view of the page, used to aim lookups at held keys
  logic [KEY_W-1:0] gen_keys[$];
  int               gen_count = 0;
  logic [KEY_W-1:0] key_pool [16];
  bit               calm = 0;
  bit               fill_done = 0;

  function automatic result_t page_apply(input item_t it);
    result_t r;
    int lo, hi, mid, i;
    r = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        page_count = 0;
        page_link = '0;
      end
      CMD_INSERT: begin
        if (page_count >= ENTRY_SLOTS) begin
          r.status = 1'b1;
        end else begin
          // upper bound: equal keys keep insertion order
          lo = 0;
          hi = page_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (page_keys[mid] <= it.key) lo = mid + 1;
            else hi = mid;
          end
          for (i = page_count; i > lo; i--) begin
            page_keys[i] = page_keys[i-1];
            page_recs[i] = page_recs[i-1];
          end
          page_keys[lo] = it.key;
          page_recs[lo] = it.record_id;
          page_count++;
        end
      end
      CMD_LOOKUP: begin
        lo = 0;
        hi = page_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (page_keys[mid] < it.key) lo = mid + 1;
          else hi = mid;
        end
        if (lo < page_count && page_keys[lo] == it.key) begin
          r.found = 1'b1;
          r.found_record = page_recs[lo];
        end
      end
      default: page_link = it.link_addr;
    endcase
    r.count_now    = 9'(page_count);
    r.full_flag    = (page_count == ENTRY_SLOTS);
    r.link_present = (page_link != '0);
    r.link_value   = page_link;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.found !== want.found)
      report_error($sformatf("found got %b want %b", got.found, want.found));
    if (got.found_record !== want.found_record)
      report_error($sformatf("found_record got %h want %h", got.found_record,
                             want.found_record));
    if (got.count_now !== want.count_now)
      report_error($sformatf("count_now got %0d want %0d", got.count_now, want.count_now));
    if (got.full_flag !== want.full_flag)
      report_error($sformatf("full_flag got %b want %b", got.full_flag, want.full_flag));
    if (got.link_present !== want.link_present)
      report_error($sformatf("link_present got %b want %b", got.link_present,
                             want.link_present));
    if (got.link_value !== want.link_value)
      report_error($sformatf("link_value got %h want %h", got.link_value, want.link_value));
    if (got.status !== want.status)
      report_error($sformatf("status got %b want %b", got.status, want.status));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_item(input cmd_t c, input logic [63:0] k, input logic [63:0] rec,
                           input logic [63:0] lnk, input bit drain);
    send_t s;
    s.it.cmd       = c;
    s.it.key       = k;
    s.it.record_id = rec;
    s.it.link_addr = lnk;
    s.drain        = drain;
    if ($urandom_range(0, 29) == 0) calm = !calm;
    s.gap = calm ? 0 : $urandom_range(0, 4);
    items_to_send.push_back(s);
    items_total++;
    if (c == CMD_CLEAR) begin
      gen_keys.delete();
      gen_count = 0;
    end else if (c == CMD_INSERT && gen_count < ENTRY_SLOTS) begin
      gen_keys.push_back(k);
      gen_count++;
    end
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return key_pool[$urandom_range(0, 15)];
      default: return rand64();
    endcase
  endfunction

  // mostly keys already on the page, or their neighbours, so both hits and misses occur
  function automatic logic [63:0] lookup_key();
    logic [63:0] k;
    if (gen_keys.size() == 0 || $urandom_range(0, 3) == 0) return pick_key();
    k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    case ($urandom_range(0, 5))
      0:       return k + 1;
      1:       return k - 1;
      default: return k;
    endcase
  endfunction

  task automatic random_episode();
    int len, r;
    if ($urandom_range(0, 4) != 0)
      push_item(CMD_CLEAR, rand64(), rand64(), rand64(), $urandom_range(0, 7) == 0);
    len = $urandom_range(4, 40);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        push_item(CMD_INSERT, pick_key(), rand64(), rand64(), 0);
      else if (r < 80)
        push_item(CMD_LOOKUP, lookup_key(), rand64(), rand64(), 0);
      else if (r < 92)
        push_item(CMD_LINK, rand64(), rand64(),
                  ($urandom_range(0, 3) == 0) ? 64'd0 : rand64(), 0);
      else
        push_item(CMD_CLEAR, rand64(), rand64(), rand64(), 0);
    end
  endtask

  // fill the page to capacity, then push a few inserts past it
  task automatic fill_episode();
    int i;
    push_item(CMD_CLEAR, rand64(), rand64(), rand64(), 1);
    for (i = 0; i < ENTRY_SLOTS + 4; i++) begin
      push_item(CMD_INSERT, ($urandom_range(0, 2) == 0) ? key_pool[$urandom_range(0, 15)]
                                                         : rand64(), rand64(), rand64(), 0);
      if (i % 20 == 0) push_item(CMD_LOOKUP, lookup_key(), rand64(), rand64(), 0);
    end
    repeat (6) push_item(CMD_LOOKUP, lookup_key(), rand64(), rand64(), 0);
    push_item(CMD_LINK, rand64(), rand64(), rand64(), 0);
    push_item(CMD_INSERT, rand64(), rand64(), rand64(), 0);
    fill_done = 1;
  endtask

  initial begin
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < 4) ? 64'(i * 3) : rand64();

    // directed items
    push_item(CMD_LOOKUP, 64'd0, '1, '1, 0);            // empty page
    push_item(CMD_INSERT, 64'd0, '1, '0, 0);
    push_item(CMD_INSERT, '1, 64'd0, '1, 0);
    push_item(CMD_INSERT, 64'd5, 64'h1111, '0, 0);
    push_item(CMD_INSERT, 64'd5, 64'h2222, '0, 0);       // equal key goes after
    push_item(CMD_LOOKUP, 64'd5, '0, '0, 0);
    push_item(CMD_LOOKUP, 64'd0, '0, '0, 0);
    push_item(CMD_LOOKUP, '1, '0, '0, 0);
    push_item(CMD_LOOKUP, 64'd6, '0, '0, 0);
    push_item(CMD_LOOKUP, 64'd4, '0, '0, 0);
    push_item(CMD_LINK, '0, '0, '1, 0);
    push_item(CMD_LINK, '1, '1, 64'd0, 0);
    push_item(CMD_LINK, '0, '0, 64'd1, 1);              // sender waits for all results
    push_item(CMD_CLEAR, '1, '1, '1, 0);
    push_item(CMD_LOOKUP, 64'd5, '0, '0, 0);
    push_item(CMD_INSERT, 64'd100, 64'hA, '0, 0);
    push_item(CMD_INSERT, 64'd50, 64'hB, '0, 0);
    push_item(CMD_INSERT, 64'd75, 64'hC, '0, 0);
    push_item(CMD_INSERT, 64'd50, 64'hD, '0, 0);
    push_item(CMD_LOOKUP, 64'd75, '0, '0, 0);
    push_item(CMD_LOOKUP, 64'd50, '0, '0, 0);
    push_item(CMD_LOOKUP, 64'd100, '0, '0, 0);
    push_item(CMD_LINK, '0, '0, 64'h8000_0000_0000_0000, 0);

    while (items_total < RANDOM_TARGET) begin
      if (!fill_done && items_total > 150) fill_episode();
      else random_episode();
    end

    while (!timed_out && (items_accepted < items_total || results_due.size() != 0)) begin
      @(negedge clk);
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    if (results_due.size() != 0)
      report_error($sformatf("%0d results never arrived", results_due.size()));
    if (!timed_out && errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin
    send_t s;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (items_to_send.size() == 0 ||
                   (items_to_send[0].drain && results_due.size() != 0)) begin
        start <= 1'b0;
      end else begin
        s = items_to_send.pop_front();
        cmd_item <= s.it;
        start <= 1'b1;
        gap_left = s.gap;
      end
    end
  end

  // monitor: samples on the rising edge
  always @(posedge clk) begin
    logic accepted;
    accepted = !rst && start && !busy;
    item_taken <= accepted;
    if (!rst && done) begin
      if (results_due.size() == 0) report_error("result with no item outstanding");
      else check_result(result_out, results_due.pop_front());
    end
    if (accepted) begin
      results_due.push_back(page_apply(cmd_item));
      items_accepted++;
    end
    idle_cycles <= (accepted || (!rst && done)) ? 0 : idle_cycles + 1;
  end

endmodule
